/* hdl/bb_pkg.sv */
// ----------------------------------------------------------------------------
// bb_pkg: shared types and helpers for the 3x3 box blur
// Holds the window type, the result job passed from front to back, and
// the reciprocal table used by the rounding divider.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package bb_pkg;

    localparam int MAX_LINE_WIDTH_DEF = 1024;
    localparam int QUEUE_DEPTH        = 2;
    localparam int RECIP_SHIFT        = 16;

    // register indexes on the config port
    localparam logic REG_FRAME_WIDTH  = 1'b0;
    localparam logic REG_FRAME_HEIGHT = 1'b1;

    // nine pixels, index row*3+col, row 0 = two rows up, col 0 = two columns left
    typedef logic [8:0][23:0] bb_win_t;

    // one result to compute
    typedef struct packed {
        bb_win_t     win;
        logic [15:0] row;
        logic [9:0]  col;
        logic [1:0]  row_start;
        logic [1:0]  col_start;
        logic        run_last;
        logic        frame_last;
    } bb_job_t;

    // floor(2^16 / (2*n)) for the pixel counts that can occur
    function automatic logic [15:0] bb_recip(input logic [3:0] n);
        logic [15:0] m;
        begin
            case (n)
                4'd1:    m = 16'd32768;
                4'd2:    m = 16'd16384;
                4'd3:    m = 16'd10922;
                4'd4:    m = 16'd8192;
                4'd6:    m = 16'd5461;
                4'd9:    m = 16'd3640;
                default: m = 16'd0;
            endcase
            return m;
        end
    endfunction

endpackage
`default_nettype wire

/* hdl/bb_front.sv */
// ----------------------------------------------------------------------------
// bb_front: pixel intake, line stores, window and result classification
// Accepts one pixel, updates the line stores and the 3x3 window, then
// pushes one job per result that the pixel causes into the queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module bb_front
    import bb_pkg::*;
#(
    parameter int MAX_LINE_WIDTH = MAX_LINE_WIDTH_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        restart,
    input  wire logic [10:0] frame_width,
    input  wire logic [15:0] frame_height,
    input  wire logic        pix_valid,
    output logic             pix_ready,
    input  wire logic [23:0] pix_data,
    output logic             job_push,
    output bb_job_t          job_data,
    input  wire logic        job_full
);

    localparam int CW = (MAX_LINE_WIDTH > 1) ? $clog2(MAX_LINE_WIDTH) : 1;
    localparam int WB = ($clog2(MAX_LINE_WIDTH + 1) > 11) ? $clog2(MAX_LINE_WIDTH + 1) : 11;
    localparam logic [WB-1:0] MAX_W = WB'(MAX_LINE_WIDTH);

    localparam logic [1:0] F_IDLE = 2'd0;
    localparam logic [1:0] F_UPD  = 2'd1;
    localparam logic [1:0] F_PUSH = 2'd2;

    logic [1:0]    state_reg, state_next;
    logic [CW-1:0] col_reg, col_next;
    logic [15:0]   row_reg, row_next;
    logic [23:0]   px_reg;
    logic [23:0]   up_rd_reg, lo_rd_reg;
    bb_win_t       win_reg;
    logic [3:0]    pend_reg, pend_next;
    logic [15:0]   e_row_reg [4];
    logic [9:0]    e_col_reg [4];
    logic [1:0]    e_rs_reg  [4];
    logic [1:0]    e_cs_reg  [4];

    logic [23:0] upper_mem [MAX_LINE_WIDTH];
    logic [23:0] lower_mem [MAX_LINE_WIDTH];

    logic          accept;
    logic [WB-1:0] w_eff, w_m1, col_ext;
    logic [15:0]   h_m1;
    logic          r_ge1, r_ge2, c_ge1, c_ge2, c_end, r_end;
    logic [1:0]    rs_a, rs_b, cs_a, cs_b;
    logic [9:0]    col10, colm1;
    logic [15:0]   rowm1;
    logic [1:0]    sel;
    logic          sel_any;

    assign pix_ready = (state_reg == F_IDLE);
    assign accept    = pix_valid && pix_ready;

    // effective geometry
    always_comb begin
        if (frame_width == 11'd0) begin
            w_eff = WB'(1);
        end else if (WB'(frame_width) > MAX_W) begin
            w_eff = MAX_W;
        end else begin
            w_eff = WB'(frame_width);
        end
        w_m1    = w_eff - WB'(1);
        h_m1    = (frame_height == 16'd0) ? 16'd0 : frame_height - 16'd1;
        col_ext = WB'(col_reg);
    end

    // position flags and clipped neighborhood starts
    always_comb begin
        r_ge1 = (row_reg != 16'd0);
        r_ge2 = (row_reg > 16'd1);
        c_ge1 = (col_reg != '0);
        c_ge2 = (col_ext > WB'(1));
        c_end = (col_ext == w_m1);
        r_end = (row_reg == h_m1);
        rs_a  = r_ge2 ? 2'd0 : 2'd1;
        rs_b  = r_ge1 ? 2'd1 : 2'd2;
        cs_a  = c_ge2 ? 2'd0 : 2'd1;
        cs_b  = c_ge1 ? 2'd1 : 2'd2;
        col10 = col_ext[9:0];
        colm1 = col10 - 10'd1;
        rowm1 = row_reg - 16'd1;
    end

    // pick the pending result with the lowest index
    always_comb begin
        sel     = 2'd0;
        sel_any = 1'b0;
        for (int k = 3; k >= 0; k--) begin
            if (pend_reg[k]) begin
                sel     = 2'(k);
                sel_any = 1'b1;
            end
        end
        pend_next = pend_reg;
        pend_next[sel] = 1'b0;
    end

    assign job_push = (state_reg == F_PUSH) && sel_any && !job_full;

    always_comb begin
        job_data.win        = win_reg;
        job_data.row        = e_row_reg[sel];
        job_data.col        = e_col_reg[sel];
        job_data.row_start  = e_rs_reg[sel];
        job_data.col_start  = e_cs_reg[sel];
        job_data.run_last   = (pend_next == 4'd0);
        job_data.frame_last = (sel == 2'd3);
    end

    // control sequence
    always_comb begin
        state_next = state_reg;
        col_next   = col_reg;
        row_next   = row_reg;
        case (state_reg)
            F_IDLE: begin
                if (accept) begin
                    state_next = F_UPD;
                end
            end
            F_UPD: begin
                state_next = F_PUSH;
                if (c_end) begin
                    col_next = '0;
                    row_next = r_end ? 16'd0 : row_reg + 16'd1;
                end else begin
                    col_next = col_reg + CW'(1);
                end
            end
            F_PUSH: begin
                if (!sel_any || (job_push && pend_next == 4'd0)) begin
                    state_next = F_IDLE;
                end
            end
            default: state_next = F_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= F_IDLE;
            col_reg   <= '0;
            row_reg   <= 16'd0;
            pend_reg  <= 4'd0;
            win_reg   <= '0;
        end else begin
            state_reg <= state_next;
            if (restart) begin
                col_reg <= '0;
                row_reg <= 16'd0;
            end else begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
            if (state_reg == F_UPD) begin
                pend_reg <= {r_end && c_end, r_end && c_ge1, r_ge1 && c_end, r_ge1 && c_ge1};
                for (int i = 0; i < 3; i++) begin
                    win_reg[i*3]     <= win_reg[i*3 + 1];
                    win_reg[i*3 + 1] <= win_reg[i*3 + 2];
                end
                win_reg[2] <= up_rd_reg;
                win_reg[5] <= lo_rd_reg;
                win_reg[8] <= px_reg;
            end else if (job_push) begin
                pend_reg <= pend_next;
            end
        end
    end

    // result descriptors
    always_ff @(posedge aclk) begin
        if (state_reg == F_UPD) begin
            e_row_reg[0] <= rowm1;   e_col_reg[0] <= colm1; e_rs_reg[0] <= rs_a; e_cs_reg[0] <= cs_a;
            e_row_reg[1] <= rowm1;   e_col_reg[1] <= col10; e_rs_reg[1] <= rs_a; e_cs_reg[1] <= cs_b;
            e_row_reg[2] <= row_reg; e_col_reg[2] <= colm1; e_rs_reg[2] <= rs_b; e_cs_reg[2] <= cs_a;
            e_row_reg[3] <= row_reg; e_col_reg[3] <= col10; e_rs_reg[3] <= rs_b; e_cs_reg[3] <= cs_b;
        end
    end

    // line stores: read at intake, write back on update
    always_ff @(posedge aclk) begin
        if (accept) begin
            px_reg    <= pix_data;
            up_rd_reg <= upper_mem[col_reg];
            lo_rd_reg <= lower_mem[col_reg];
        end
        if (state_reg == F_UPD) begin
            upper_mem[col_reg] <= lo_rd_reg;
            lower_mem[col_reg] <= px_reg;
        end
    end

endmodule
`default_nettype wire

/* hdl/bb_queue.sv */
// ----------------------------------------------------------------------------
// bb_queue: short job queue between front and back
// Two-entry register queue so the front and the back stall independently.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module bb_queue
    import bb_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    push,
    input  bb_job_t      push_data,
    output logic         full,
    input  wire logic    pop,
    output bb_job_t      pop_data,
    output logic         empty
);

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int NW = $clog2(QUEUE_DEPTH + 1);

    bb_job_t       mem_reg [QUEUE_DEPTH];
    logic [PW-1:0] wp_reg, rp_reg;
    logic [NW-1:0] cnt_reg;

    assign full     = (cnt_reg == NW'(QUEUE_DEPTH));
    assign empty    = (cnt_reg == '0);
    assign pop_data = mem_reg[rp_reg];

    // pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (push) begin
                wp_reg <= (wp_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wp_reg + PW'(1);
            end
            if (pop) begin
                rp_reg <= (rp_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rp_reg + PW'(1);
            end
            if (push && !pop) begin
                cnt_reg <= cnt_reg + NW'(1);
            end else if (pop && !push) begin
                cnt_reg <= cnt_reg - NW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wp_reg] <= push_data;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        full |-> !push)
        else $error("job pushed into full queue");
    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        empty |-> !pop)
        else $error("job popped from empty queue");
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= NW'(QUEUE_DEPTH))
        else $error("queue count out of range");

endmodule
`default_nettype wire

/* hdl/bb_back.sv */
// ----------------------------------------------------------------------------
// bb_back: clipped window mean with half-up rounding
// Sums the clipped neighborhood, divides by reciprocal multiply with one
// correction step, and holds the result in the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module bb_back
    import bb_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        job_empty,
    input  bb_job_t          job_data,
    output logic             job_pop,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [15:0]      out_row,
    output logic [9:0]       out_col,
    output logic [7:0]       out_blue,
    output logic [7:0]       out_green,
    output logic [7:0]       out_red,
    output logic             out_run_last,
    output logic             out_frame_last
);

    localparam logic [1:0] B_IDLE = 2'd0;
    localparam logic [1:0] B_MUL  = 2'd1;
    localparam logic [1:0] B_FIX  = 2'd2;

    logic [1:0]  state_reg;
    logic [12:0] num_reg  [3];
    logic [28:0] prod_reg [3];
    logic [3:0]  n_reg;
    logic [15:0] row_reg;
    logic [9:0]  col_reg;
    logic        rl_reg, fl_reg;
    logic        ov_reg;
    logic [7:0]  ob_reg, og_reg, or_reg;
    logic [15:0] orow_reg;
    logic [9:0]  ocol_reg;
    logic        orl_reg, ofl_reg;

    logic [11:0] sum [3];
    logic [3:0]  n_cnt;
    logic [12:0] q0 [3];
    logic [12:0] rem [3];
    logic [7:0]  q [3];
    logic [12:0] dv;
    logic        out_free;

    assign out_free = !ov_reg || out_ready;
    assign job_pop  = (state_reg == B_IDLE) && !job_empty;

    // clipped neighborhood sums
    always_comb begin
        n_cnt = 4'd0;
        for (int ch = 0; ch < 3; ch++) begin
            sum[ch] = 12'd0;
        end
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                if (2'(i) >= job_data.row_start && 2'(j) >= job_data.col_start) begin
                    n_cnt = n_cnt + 4'd1;
                    for (int ch = 0; ch < 3; ch++) begin
                        sum[ch] = sum[ch] + 12'(job_data.win[i*3 + j][ch*8 +: 8]);
                    end
                end
            end
        end
    end

    // quotient estimate correction
    always_comb begin
        dv = {8'd0, n_reg, 1'b0};
        for (int ch = 0; ch < 3; ch++) begin
            q0[ch]  = prod_reg[ch][RECIP_SHIFT +: 13];
            rem[ch] = num_reg[ch] - 13'(q0[ch] * dv);
            q[ch]   = (rem[ch] >= dv) ? 8'(q0[ch] + 13'd1) : q0[ch][7:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= B_IDLE;
            ov_reg    <= 1'b0;
        end else begin
            case (state_reg)
                B_IDLE: begin
                    if (!job_empty) begin
                        state_reg <= B_MUL;
                    end
                end
                B_MUL: state_reg <= B_FIX;
                B_FIX: begin
                    if (out_free) begin
                        state_reg <= B_IDLE;
                    end
                end
                default: state_reg <= B_IDLE;
            endcase
            if (state_reg == B_FIX && out_free) begin
                ov_reg <= 1'b1;
            end else if (out_ready) begin
                ov_reg <= 1'b0;
            end
        end
    end

    // datapath stages
    always_ff @(posedge aclk) begin
        if (job_pop) begin
            for (int ch = 0; ch < 3; ch++) begin
                num_reg[ch] <= {sum[ch], 1'b0} + 13'(n_cnt);
            end
            n_reg   <= n_cnt;
            row_reg <= job_data.row;
            col_reg <= job_data.col;
            rl_reg  <= job_data.run_last;
            fl_reg  <= job_data.frame_last;
        end
        if (state_reg == B_MUL) begin
            for (int ch = 0; ch < 3; ch++) begin
                prod_reg[ch] <= 29'(num_reg[ch]) * 29'(bb_recip(n_reg));
            end
        end
        if (state_reg == B_FIX && out_free) begin
            ob_reg   <= q[0];
            og_reg   <= q[1];
            or_reg   <= q[2];
            orow_reg <= row_reg;
            ocol_reg <= col_reg;
            orl_reg  <= rl_reg;
            ofl_reg  <= fl_reg;
        end
    end

    assign out_valid      = ov_reg;
    assign out_row        = orow_reg;
    assign out_col        = ocol_reg;
    assign out_blue       = ob_reg;
    assign out_green      = og_reg;
    assign out_red        = or_reg;
    assign out_run_last   = orl_reg;
    assign out_frame_last = ofl_reg;

endmodule
`default_nettype wire

/* hdl/box_blur_3x3_edge_clipped.sv */
// ----------------------------------------------------------------------------
// box_blur_3x3_edge_clipped: 3x3 box blur over an RGB pixel stream
// Pixels enter in raster order on s_axis; blurred pixels with their row and
// column leave on m_axis. The neighborhood is clipped at the frame edges and
// each channel mean is rounded half up.
// Registers (APB): 0x0 frame_width (reset 1024), 0x4 frame_height (reset 1).
// A register write restarts the frame at row 0, column 0.
// Input pixel (r,c) yields (r-1,c-1), plus (r-1,c) at a row end; on the last
// row also (r,c-1), plus (r,c) at the row end. tlast marks the last result of
// one input pixel, tuser marks the bottom-right pixel of the frame.
// The intake accepts a pixel, updates the line stores and window, then pushes
// one job per result it causes, and takes no new pixel until it has pushed them;
// the back end takes each result through a sum, a reciprocal multiply and a
// correction, and takes no new job until its result is in the output register.
// A two-entry job queue separates the intake from the back end. On a stall of
// m_axis the output register holds and the back end and queue fill before
// s_axis_tready drops.
// Reset clears position, window and control; line store contents are
// undefined until written.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module box_blur_3x3_edge_clipped
    import bb_pkg::*;
#(
    parameter int MAX_LINE_WIDTH = MAX_LINE_WIDTH_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,   // in_blue, in_green, in_red
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [55:0]      m_axis_tdata,   // out_row, out_col, out_blue, out_green, out_red
    output logic             m_axis_tlast,
    output logic             m_axis_tuser,   // frame_last
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    logic [10:0] width_reg;
    logic [15:0] height_reg;
    logic        cfg_wr;
    logic        q_push, q_full, q_pop, q_empty;
    bb_job_t     q_in, q_out;
    logic [15:0] o_row;
    logic [9:0]  o_col;
    logic [7:0]  o_b, o_g, o_r;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= 11'd1024;
            height_reg <= 16'd1;
        end else if (cfg_wr) begin
            case (paddr[2])
                REG_FRAME_WIDTH:  width_reg  <= pwdata[10:0];
                REG_FRAME_HEIGHT: height_reg <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // register readback
    always_comb begin
        case (paddr[2])
            REG_FRAME_WIDTH:  prdata = {21'd0, width_reg};
            REG_FRAME_HEIGHT: prdata = {16'd0, height_reg};
            default:          prdata = 32'd0;
        endcase
    end

    bb_front #(
        .MAX_LINE_WIDTH(MAX_LINE_WIDTH)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .restart      (cfg_wr),
        .frame_width  (width_reg),
        .frame_height (height_reg),
        .pix_valid    (s_axis_tvalid),
        .pix_ready    (s_axis_tready),
        .pix_data     (s_axis_tdata),
        .job_push     (q_push),
        .job_data     (q_in),
        .job_full     (q_full)
    );

    bb_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_out),
        .empty     (q_empty)
    );

    bb_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .job_empty      (q_empty),
        .job_data       (q_out),
        .job_pop        (q_pop),
        .out_valid      (m_axis_tvalid),
        .out_ready      (m_axis_tready),
        .out_row        (o_row),
        .out_col        (o_col),
        .out_blue       (o_b),
        .out_green      (o_g),
        .out_red        (o_r),
        .out_run_last   (m_axis_tlast),
        .out_frame_last (m_axis_tuser)
    );

    assign m_axis_tdata = {6'd0, o_r, o_g, o_b, o_col, o_row};

endmodule
`default_nettype wire

/* verif/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top: stream testbench for the 3x3 edge-clipped box blur
// Drives RGB pixels through s_axis, predicts each blurred pixel with an
// in-bench window and line-store model, and compares every m_axis transaction
// field by field. Covers random frame geometries under four idling phases
// on the two sides, plus directed cases and the extremes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb_top;
    import bb_pkg::*;

    localparam int LINE_MAX  = 1024;
    localparam int CYCLE_CAP = 400000;

    typedef struct packed {
        logic [15:0] row;
        logic [9:0]  col;
        logic [7:0]  blue;
        logic [7:0]  green;
        logic [7:0]  red;
        logic        run_last;
        logic        frame_last;
    } blur_pix_t;

    // one directed row: pixel plus optional typed-in last result
    typedef struct {
        logic [23:0] pixel;
        logic        has_fixed;
        blur_pix_t   fixed;
    } pix_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;   // in_blue, in_green, in_red
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [55:0] m_axis_tdata;        // out_row, out_col, out_blue, out_green, out_red
    logic        m_axis_tlast;
    logic        m_axis_tuser;        // frame_last
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    box_blur_3x3_edge_clipped dut (.*);

    always #5 aclk = ~aclk;

    // predictor state
    logic [23:0] upper_line [LINE_MAX];
    logic [23:0] lower_line [LINE_MAX];
    logic [23:0] win [3][3];
    int unsigned cfg_width = 1024, cfg_height = 1;
    int unsigned col_pos = 0, row_pos = 0;

    blur_pix_t   blur_queue[$];
    int          err_count = 0;
    int          cycle_count = 0;
    int          send_idle_pct = 0, recv_stall_pct = 0;

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        err_count++;
    endtask

    function automatic blur_pix_t clipped_mean(input int orow, input int ocol,
                                              input int r0, input int c0);
        blur_pix_t p;
        int sb, sg, sr, n;
        sb = 0; sg = 0; sr = 0; n = 0;
        for (int i = r0; i < 3; i++)
            for (int j = c0; j < 3; j++) begin
                sb += win[i][j][7:0];
                sg += win[i][j][15:8];
                sr += win[i][j][23:16];
                n++;
            end
        p.row = 16'(orow); p.col = 10'(ocol);
        p.blue = 8'((2*sb + n) / (2*n));
        p.green = 8'((2*sg + n) / (2*n));
        p.red = 8'((2*sr + n) / (2*n));
        p.run_last = 1'b0; p.frame_last = 1'b0;
        return p;
    endfunction

    // advance the model by one pixel and queue the blurred pixels it releases
    task automatic predict_blur(input logic [23:0] px);
        int unsigned w, h, c, r;
        blur_pix_t outs[$];
        w = (cfg_width == 0) ? 1 : (cfg_width > LINE_MAX ? LINE_MAX : cfg_width);
        h = (cfg_height == 0) ? 1 : cfg_height;
        c = (col_pos >= w) ? w - 1 : col_pos;
        r = (row_pos >= h) ? h - 1 : row_pos;
        for (int i = 0; i < 3; i++) begin
            win[i][0] = win[i][1];
            win[i][1] = win[i][2];
        end
        win[0][2] = upper_line[c];
        win[1][2] = lower_line[c];
        win[2][2] = px;
        upper_line[c] = lower_line[c];
        lower_line[c] = px;
        if (r >= 1) begin
            if (c >= 1) outs.push_back(clipped_mean(r-1, c-1, r >= 2 ? 0 : 1, c >= 2 ? 0 : 1));
            if (c == w-1) outs.push_back(clipped_mean(r-1, c, r >= 2 ? 0 : 1, c >= 1 ? 1 : 2));
        end
        if (r == h-1) begin
            if (c >= 1) outs.push_back(clipped_mean(r, c-1, r >= 1 ? 1 : 2, c >= 2 ? 0 : 1));
            if (c == w-1) begin
                outs.push_back(clipped_mean(r, c, r >= 1 ? 1 : 2, c >= 1 ? 1 : 2));
                outs[$].frame_last = 1'b1;
            end
        end
        if (outs.size() > 0) outs[$].run_last = 1'b1;
        foreach (outs[k]) blur_queue.push_back(outs[k]);
        if (c == w-1) begin
            col_pos = 0;
            row_pos = (r == h-1) ? 0 : r + 1;
        end else begin
            col_pos = c + 1;
            row_pos = r;
        end
    endtask

    // result checker and run timeout
    always @(posedge aclk) begin
        blur_pix_t e;
        if (aresetn) begin
            cycle_count <= cycle_count + 1;
            if (m_axis_tvalid && m_axis_tready) begin
                if (blur_queue.size() == 0) begin
                    report_mismatch("unexpected transaction row", m_axis_tdata[15:0], -1);
                end else begin
                    e = blur_queue.pop_front();
                    if (m_axis_tdata[15:0] !== e.row)
                        report_mismatch("row", m_axis_tdata[15:0], e.row);
                    if (m_axis_tdata[25:16] !== e.col)
                        report_mismatch("col", m_axis_tdata[25:16], e.col);
                    if (m_axis_tdata[33:26] !== e.blue)
                        report_mismatch("blue", m_axis_tdata[33:26], e.blue);
                    if (m_axis_tdata[41:34] !== e.green)
                        report_mismatch("green", m_axis_tdata[41:34], e.green);
                    if (m_axis_tdata[49:42] !== e.red)
                        report_mismatch("red", m_axis_tdata[49:42], e.red);
                    if (m_axis_tlast !== e.run_last)
                        report_mismatch("tlast", m_axis_tlast, e.run_last);
                    if (m_axis_tuser !== e.frame_last)
                        report_mismatch("tuser", m_axis_tuser, e.frame_last);
                end
            end
        end
        if (cycle_count >= CYCLE_CAP) begin
            $display("FAIL box_blur_3x3_edge_clipped");
            $finish;
        end
    end

    always @(negedge aclk)
        m_axis_tready <= aresetn && ($urandom_range(99) >= recv_stall_pct);

    task automatic apb_write(input int idx, input logic [31:0] value);
        @(negedge aclk);
        psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
        paddr <= 3'(idx * 4); pwdata <= value;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        @(negedge aclk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        if (idx == REG_FRAME_WIDTH) cfg_width = 32'(value[10:0]);
        else cfg_height = 32'(value[15:0]);
        col_pos = 0; row_pos = 0;
    endtask

    // wait for all results, then a settling margin, before a register write
    task automatic drain_blur;
        while (blur_queue.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    task automatic set_geometry(input int w, input int h);
        drain_blur();
        apb_write(REG_FRAME_WIDTH, w);
        apb_write(REG_FRAME_HEIGHT, h);
    endtask

    // one pixel transaction with random sender idling
    task automatic send_pixel(input logic [23:0] px);
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= px;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        predict_blur(px);
        @(negedge aclk);
        s_axis_tvalid <= 1'b0;
    endtask

    function automatic logic [23:0] rand_pixel();
        case ($urandom_range(5))
            0: return 24'h000000;
            1: return 24'hFFFFFF;
            default: return $urandom();
        endcase
    endfunction

    // send whole frames of random pixels at a new geometry
    task automatic send_frames(input int w, input int h, input int nframes);
        set_geometry(w, h);
        for (int f = 0; f < nframes; f++)
            for (int i = 0; i < w*h; i++) send_pixel(rand_pixel());
    endtask

    pix_row_t dir_rows[$];
    int       sent;
    int       geo_w, geo_h;

    initial begin
        for (int i = 0; i < LINE_MAX; i++) begin
            upper_line[i] = '0; lower_line[i] = '0;
        end
        foreach (win[i, j]) win[i][j] = '0;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: 1x1 frame, result equals the pixel itself
        set_geometry(1, 1);
        dir_rows.push_back('{24'hFFFFFF, 1'b1, '{0, 0, 8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b1}});
        dir_rows.push_back('{24'h000000, 1'b1, '{0, 0, 8'h00, 8'h00, 8'h00, 1'b1, 1'b1}});
        dir_rows.push_back('{24'h01FF80, 1'b1, '{0, 0, 8'h80, 8'hFF, 8'h01, 1'b1, 1'b1}});
        foreach (dir_rows[i]) begin
            send_pixel(dir_rows[i].pixel);
            if (dir_rows[i].has_fixed && blur_queue.size() > 0 &&
                blur_queue[$] != dir_rows[i].fixed)
                report_mismatch("directed row", i, -1);
        end
        // directed: 3x3 checkerboard of extremes, clip counts 4, 6 and 9 show up
        set_geometry(3, 3);
        for (int i = 0; i < 9; i++) send_pixel((i % 2) ? 24'hFFFFFF : 24'h000000);
        // directed: rounding half-up on a 2-pixel row
        set_geometry(2, 1);
        send_pixel(24'h000001);
        send_pixel(24'h000000);
        send_pixel(24'h0000FF);
        send_pixel(24'h0000FE);
        // zero geometry behaves as 1x1
        set_geometry(0, 0);
        send_pixel(24'h123456);
        send_pixel(24'hABCDEF);

        // random phases: no idle, sender idle, receiver stall, both
        sent = 0;
        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct  = (ph == 1) ? 55 : (ph == 3) ? 24 : 0;
            recv_stall_pct = (ph == 2) ? 55 : (ph == 3) ? 24 : 0;
            for (int k = 0; k < 4; k++) begin
                geo_w = $urandom_range(1, 9);
                geo_h = $urandom_range(1, 5);
                send_frames(geo_w, geo_h, 1);
                sent += geo_w * geo_h;
            end
            // hold off until every blurred pixel has come out
            drain_blur();
        end
        // extremes: start of a full-width row, and a tall narrow frame
        send_idle_pct = 0; recv_stall_pct = 10;
        send_frames(1024, 1, 0);
        for (int i = 0; i < 16; i++) send_pixel(rand_pixel());
        send_frames(1, 70, 1);
        // write above the maximum line width: width saturates, tallest height
        send_frames(2047, 1, 0);
        for (int i = 0; i < 16; i++) send_pixel(rand_pixel());
        send_frames(2, 65535, 0);
        for (int i = 0; i < 8; i++) send_pixel(rand_pixel());
        // mid-frame restart by a geometry write, then a complete frame
        send_frames(4, 3, 1);

        drain_blur();
        repeat (50) @(posedge aclk);
        if (err_count == 0) begin
            $display("PASS box_blur_3x3_edge_clipped");
        end else begin
            $display("FAIL box_blur_3x3_edge_clipped");
        end
        $finish;
    end

endmodule

/* box_blur_3x3_edge_clipped.f */
hdl/bb_pkg.sv
hdl/bb_front.sv
hdl/bb_queue.sv
hdl/bb_back.sv
hdl/box_blur_3x3_edge_clipped.sv
verif/tb_top.sv
